### hw/rtl/pgm_pkg.sv
// Shared types, constants and codes for the plane grid mesh generator.
// Depends on nothing; every other file of the block depends on it.
package pgm_pkg;

  localparam int unsigned MaxResolution = 256;
  localparam int unsigned IdxW          = 16;
  localparam int unsigned PosW          = 32;
  localparam int unsigned ResW          = 9;
  localparam int unsigned QuoW          = 8;
  localparam int unsigned SizeW         = 2 * ResW;
  localparam int unsigned CfgIdxW       = 8;
  localparam int unsigned CfgDataW      = 32;
  localparam int unsigned DivStages     = QuoW / 2;
  localparam int unsigned SetupCntW     = 6;

  // Error codes of a result word.
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_RES   = 2'd1;
  localparam logic [1:0] ERR_RANGE = 2'd2;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] REG_PLANE_WIDTH  = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_PLANE_HEIGHT = 8'd1;
  localparam logic [CfgIdxW-1:0] REG_COLUMNS      = 8'd2;
  localparam logic [CfgIdxW-1:0] REG_ROWS         = 8'd3;

  // Reset values of the registers and of the values derived from them.
  localparam logic [PosW-1:0] PlaneReset = 32'h0001_0000;
  localparam logic [PosW-1:0] HalfReset  = 32'h0000_8000;
  localparam logic [ResW-1:0] ResReset   = 9'd2;
  localparam logic [SizeW-1:0] SizeReset = 18'd4;

  typedef struct packed {
    logic [IdxW-1:0] vertex_index;
  } in_t;

  typedef struct packed {
    logic signed [PosW-1:0] pos_x;
    logic signed [PosW-1:0] pos_y;
    logic                   has_quad;
    logic [IdxW-1:0]        first_a;
    logic [IdxW-1:0]        first_b;
    logic [IdxW-1:0]        first_c;
    logic [IdxW-1:0]        second_a;
    logic [IdxW-1:0]        second_b;
    logic [IdxW-1:0]        second_c;
    logic [1:0]             error;
  } out_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_t;

  // Grid geometry derived from the registers, held stable between writes.
  typedef struct packed {
    logic signed [PosW-1:0] step_x;
    logic signed [PosW-1:0] step_y;
    logic signed [PosW-1:0] half_x;
    logic signed [PosW-1:0] half_y;
    logic [ResW-1:0]        columns;
    logic [ResW-1:0]        rows;
    logic [SizeW-1:0]       size;
    logic                   res_bad;
  } geom_t;

  // One slot of the index divider pipeline.
  typedef struct packed {
    logic [ResW-1:0] rem;
    logic [QuoW-1:0] dvd;
    logic [QuoW-1:0] quo;
    logic [IdxW-1:0] vidx;
    logic [1:0]      err;
  } div_t;

endpackage

### hw/rtl/pgm_if.sv
// Valid/ready channel interfaces of the plane grid mesh generator.
// Depends on pgm_pkg for the word types.
interface pgm_in_if;
  logic          valid;
  logic          ready;
  pgm_pkg::in_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pgm_out_if;
  logic          valid;
  logic          ready;
  pgm_pkg::out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pgm_cfg_if;
  logic          valid;
  logic          ready;
  pgm_pkg::cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/pgm_setup.sv
// Configuration registers and the serial divider that derives the grid steps.
// Depends on pgm_pkg and pgm_cfg_if.
module pgm_setup (
  input  logic          clk_i,
  input  logic          rst_ni,
  pgm_cfg_if.sink       cfg_i,
  output logic          busy_o,
  output pgm_pkg::geom_t geom_o
);
  import pgm_pkg::*;

  localparam logic [SetupCntW-1:0] CntLoad = 6'd0;
  localparam logic [SetupCntW-1:0] CntDone = 6'd33;

  logic [PosW-1:0]      width_q, height_q;
  logic [ResW-1:0]      cols_q, rows_q;
  logic                 busy_q;
  logic [SetupCntW-1:0] cnt_q;
  logic [PosW-1:0]      dvd_x_q, dvd_y_q;
  logic [ResW-1:0]      rem_x_q, rem_y_q;
  logic                 neg_x_q, neg_y_q;
  geom_t                geom_q;

  logic            cfg_acc;
  logic [ResW-1:0] div_x, div_y;
  logic [ResW:0]   t_x, t_y, s_x, s_y;
  logic            ge_x, ge_y;
  logic [PosW-1:0] mag_x, mag_y;
  logic            bad_cols, bad_rows;

  assign cfg_i.ready = !busy_q;
  assign cfg_acc     = cfg_i.valid && cfg_i.ready;
  assign busy_o      = busy_q;
  assign geom_o      = geom_q;

  // One quotient bit per cycle, restoring, on the magnitude of the extent.
  always_comb begin
    div_x = cols_q - 9'd1;
    div_y = rows_q - 9'd1;
    t_x   = {rem_x_q, dvd_x_q[PosW-1]};
    t_y   = {rem_y_q, dvd_y_q[PosW-1]};
    ge_x  = t_x >= {1'b0, div_x};
    ge_y  = t_y >= {1'b0, div_y};
    s_x   = t_x - {1'b0, div_x};
    s_y   = t_y - {1'b0, div_y};
    mag_x = width_q[PosW-1] ? (~width_q + 32'd1) : width_q;
    mag_y = height_q[PosW-1] ? (~height_q + 32'd1) : height_q;
    bad_cols = (cols_q < 9'd2) || (cols_q > 9'(MaxResolution));
    bad_rows = (rows_q < 9'd2) || (rows_q > 9'(MaxResolution));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q        <= PlaneReset;
      height_q       <= PlaneReset;
      cols_q         <= ResReset;
      rows_q         <= ResReset;
      busy_q         <= 1'b0;
      cnt_q          <= CntLoad;
      dvd_x_q        <= '0;
      dvd_y_q        <= '0;
      rem_x_q        <= '0;
      rem_y_q        <= '0;
      neg_x_q        <= 1'b0;
      neg_y_q        <= 1'b0;
      geom_q.step_x  <= PlaneReset;
      geom_q.step_y  <= PlaneReset;
      geom_q.half_x  <= HalfReset;
      geom_q.half_y  <= HalfReset;
      geom_q.columns <= ResReset;
      geom_q.rows    <= ResReset;
      geom_q.size    <= SizeReset;
      geom_q.res_bad <= 1'b0;
    end else if (cfg_acc) begin
      case (cfg_i.data.index)
        REG_PLANE_WIDTH:  width_q  <= cfg_i.data.data;
        REG_PLANE_HEIGHT: height_q <= cfg_i.data.data;
        REG_COLUMNS:      cols_q   <= cfg_i.data.data[ResW-1:0];
        REG_ROWS:         rows_q   <= cfg_i.data.data[ResW-1:0];
        default: ;
      endcase
      busy_q <= 1'b1;
      cnt_q  <= CntLoad;
    end else if (busy_q) begin
      if (cnt_q == CntLoad) begin
        dvd_x_q <= mag_x;
        dvd_y_q <= mag_y;
        rem_x_q <= '0;
        rem_y_q <= '0;
        neg_x_q <= width_q[PosW-1];
        neg_y_q <= height_q[PosW-1];
        cnt_q   <= cnt_q + 6'd1;
      end else if (cnt_q == CntDone) begin
        // The quotient has replaced the dividend; restore the sign.
        geom_q.step_x  <= neg_x_q ? (~dvd_x_q + 32'd1) : dvd_x_q;
        geom_q.step_y  <= neg_y_q ? (~dvd_y_q + 32'd1) : dvd_y_q;
        geom_q.half_x  <= $signed(width_q) >>> 1;
        geom_q.half_y  <= $signed(height_q) >>> 1;
        geom_q.columns <= cols_q;
        geom_q.rows    <= rows_q;
        geom_q.size    <= {{ResW{1'b0}}, cols_q} * {{ResW{1'b0}}, rows_q};
        geom_q.res_bad <= bad_cols || bad_rows;
        busy_q         <= 1'b0;
      end else begin
        rem_x_q <= ge_x ? s_x[ResW-1:0] : t_x[ResW-1:0];
        rem_y_q <= ge_y ? s_y[ResW-1:0] : t_y[ResW-1:0];
        dvd_x_q <= {dvd_x_q[PosW-2:0], ge_x};
        dvd_y_q <= {dvd_y_q[PosW-2:0], ge_y};
        cnt_q   <= cnt_q + 6'd1;
      end
    end
  end

endmodule

### hw/rtl/pgm_div_stage.sv
// One stage of the index divider: two restoring quotient bits per stage.
// Depends on pgm_pkg.
module pgm_div_stage (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  pgm_pkg::div_t             d_i,
  input  logic [pgm_pkg::ResW-1:0]  divisor_i,
  output logic                      valid_o,
  output pgm_pkg::div_t             d_o
);
  import pgm_pkg::*;

  logic            valid_q;
  div_t            d_q, d_d;
  logic [ResW:0]   t1, t2, s1, s2, dv;
  logic            ge1, ge2;
  logic [ResW-1:0] r1, r2;

  always_comb begin
    dv  = {1'b0, divisor_i};
    t1  = {d_i.rem, d_i.dvd[QuoW-1]};
    ge1 = t1 >= dv;
    s1  = t1 - dv;
    r1  = ge1 ? s1[ResW-1:0] : t1[ResW-1:0];
    t2  = {r1, d_i.dvd[QuoW-2]};
    ge2 = t2 >= dv;
    s2  = t2 - dv;
    r2  = ge2 ? s2[ResW-1:0] : t2[ResW-1:0];
    d_d      = d_i;
    d_d.rem  = r2;
    d_d.dvd  = {d_i.dvd[QuoW-3:0], 2'b00};
    d_d.quo  = {d_i.quo[QuoW-3:0], ge1, ge2};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= d_d;
    end
  end

  assign valid_o = valid_q;
  assign d_o     = d_q;

endmodule

### hw/rtl/pgm_post.sv
// Position multiply, offset and triangle corners, ending in the output register.
// Depends on pgm_pkg.
module pgm_post (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  pgm_pkg::div_t  d_i,
  input  pgm_pkg::geom_t geom_i,
  output logic           valid_o,
  output pgm_pkg::out_t  res_o
);
  import pgm_pkg::*;

  logic                   valid_a_q, valid_b_q;
  logic signed [PosW-1:0] prod_x_q, prod_y_q;
  logic [QuoW-1:0]        col_q, row_q;
  logic [IdxW-1:0]        vidx_q;
  logic [1:0]             err_q;
  out_t                   res_q, res_d;

  logic signed [PosW-1:0] px_full, py_full;
  logic [ResW-1:0]        col_next, row_next;
  logic [IdxW-1:0]        v_plus_c;
  logic                   quad;

  // After the last divider stage the remainder is the column, the quotient the row.
  // Only the low 32 bits of each product are kept, as the position wraps there.
  assign px_full = geom_i.step_x * $signed({{(PosW-QuoW){1'b0}}, d_i.rem[QuoW-1:0]});
  assign py_full = geom_i.step_y * $signed({{(PosW-QuoW){1'b0}}, d_i.quo});

  always_comb begin
    col_next = {1'b0, col_q} + 9'd1;
    row_next = {1'b0, row_q} + 9'd1;
    quad     = (col_next != geom_i.columns) && (row_next != geom_i.rows);
    v_plus_c = vidx_q + {{(IdxW-ResW){1'b0}}, geom_i.columns};
    res_d    = '0;
    res_d.error = err_q;
    if (err_q == ERR_NONE) begin
      res_d.pos_x = prod_x_q - geom_i.half_x;
      res_d.pos_y = prod_y_q - geom_i.half_y;
      if (quad) begin
        res_d.has_quad = 1'b1;
        res_d.first_a  = vidx_q;
        res_d.first_b  = vidx_q + 16'd1;
        res_d.first_c  = v_plus_c + 16'd1;
        res_d.second_a = vidx_q;
        res_d.second_b = v_plus_c + 16'd1;
        res_d.second_c = v_plus_c;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
    end else if (en_i) begin
      valid_a_q <= valid_i;
      valid_b_q <= valid_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_x_q <= px_full[PosW-1:0];
      prod_y_q <= py_full[PosW-1:0];
      col_q    <= d_i.rem[QuoW-1:0];
      row_q    <= d_i.quo;
      vidx_q   <= d_i.vidx;
      err_q    <= d_i.err;
      res_q    <= res_d;
    end
  end

  assign valid_o = valid_b_q;
  assign res_o   = res_q;

endmodule

### hw/rtl/plane_grid_mesh_generator.sv
// Plane grid mesh generator: for each vertex index of a centred grid it returns the
// Q16.16 position and, away from the last column and row, the two triangles of its quad.
// Depends on pgm_pkg, the channel interfaces, pgm_setup, pgm_div_stage and pgm_post.
//
// One word is taken every cycle unless the output stalls or setup is busy; four divider
// stages split the index into row and column two quotient bits at a time, one stage
// multiplies by the grid steps, and the last forms the result in the output register.
// A stall on the output holds the whole pipeline in place. Every configuration write
// starts a serial division of the extents by the resolution, one bit a cycle, and the
// input is held off until the new grid steps are ready.
module plane_grid_mesh_generator (
  input  logic      clk_i,
  input  logic      rst_ni,
  pgm_cfg_if.sink   cfg_i,
  pgm_in_if.sink    in_i,
  pgm_out_if.source out_o
);
  import pgm_pkg::*;

  logic  busy;
  geom_t geom;
  logic  en;
  logic  in_acc;
  div_t  stage_d [DivStages+1];
  logic  stage_v [DivStages+1];

  pgm_setup u_setup (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .busy_o (busy),
    .geom_o (geom)
  );

  // The pipeline advances whenever the output register is empty or being emptied.
  assign en          = !out_o.valid || out_o.ready;
  assign in_i.ready  = en && !busy;
  assign in_acc      = in_i.valid && in_i.ready;

  always_comb begin
    stage_v[0]      = in_acc;
    stage_d[0].rem  = {1'b0, in_i.data.vertex_index[IdxW-1:QuoW]};
    stage_d[0].dvd  = in_i.data.vertex_index[QuoW-1:0];
    stage_d[0].quo  = '0;
    stage_d[0].vidx = in_i.data.vertex_index;
    if (geom.res_bad) begin
      stage_d[0].err = ERR_RES;
    end else if ({2'b00, in_i.data.vertex_index} >= geom.size) begin
      stage_d[0].err = ERR_RANGE;
    end else begin
      stage_d[0].err = ERR_NONE;
    end
  end

  for (genvar s = 0; s < DivStages; s++) begin : g_div
    pgm_div_stage u_stage (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en),
      .valid_i   (stage_v[s]),
      .d_i       (stage_d[s]),
      .divisor_i (geom.columns),
      .valid_o   (stage_v[s+1]),
      .d_o       (stage_d[s+1])
    );
  end

  pgm_post u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (stage_v[DivStages]),
    .d_i     (stage_d[DivStages]),
    .geom_i  (geom),
    .valid_o (out_o.valid),
    .res_o   (out_o.data)
  );

endmodule
